// File: design/hsf_pkg.sv
package hsf_pkg;

    typedef enum logic [1:0] {
        OP_FLAG = 2'd0,
        OP_DATA = 2'd1,
        OP_FCS  = 2'd2,
        OP_NONE = 2'd3
    } hsf_op_t;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h8408;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] data_byte;
    } hsf_in_t;

    typedef struct packed {
        logic [7:0] line_byte;
        logic       last_of_run;
    } hsf_out_t;

    // one byte to append, as handed from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       stuff;
        logic       last;
    } hsf_entry_t;

    typedef struct packed {
        logic [9:0] bits;
        logic [3:0] len;
        logic [2:0] run;
    } hsf_stuff_t;

    function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // run counts trailing ones, capped at four; five ones in a row gets a zero
    function automatic hsf_stuff_t stuff_byte(logic [7:0] b, logic en, logic [2:0] run_in);
        hsf_stuff_t r;
        logic [3:0] pos;
        logic [2:0] c;
        r   = '0;
        pos = 4'd0;
        c   = run_in;
        for (int i = 0; i < 8; i++)
        begin
            r.bits[pos] = b[i];
            pos = pos + 4'd1;
            if (b[i])
            begin
                if (en && c == 3'd4)
                begin
                    pos = pos + 4'd1;
                    c   = 3'd0;
                end
                else if (c != 3'd4)
                begin
                    c = c + 3'd1;
                end
            end
            else
            begin
                c = 3'd0;
            end
        end
        r.len = pos;
        r.run = c;
        return r;
    endfunction

endpackage

// File: design/hdlc_stuffing_framer_crc16.sv
// HDLC transmit framer: flag/fill words go out as is, data words are bit stuffed
// and run through CRC-16/X.25, an FCS word appends the stuffed checksum (low byte
// first) and restarts the CRC. Output words are packed line bytes, first bit in
// bit 0, with last_of_run on the final byte an input word causes; operation 3 is
// dropped. The front takes one input word per cycle unless the byte queue is full
// or it is still queueing an FCS word's high byte; the back emits one line byte
// per cycle while the byte queue holds an entry and the output queue has room.
// Leading and trailing flags are the caller's job.
module hdlc_stuffing_framer_crc16 #(
    parameter int QUEUE_DEPTH = 4,
    parameter int OUT_DEPTH   = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  hsf_pkg::hsf_in_t  op_word,
    output logic              empty,
    input  logic              pop,
    output hsf_pkg::hsf_out_t line_word
);
    import hsf_pkg::*;

    logic       q_push;
    logic       q_full;
    logic       q_pop;
    logic       q_empty;
    hsf_entry_t q_wr_data;
    hsf_entry_t q_rd_data;
    logic       o_push;
    logic       o_full;
    hsf_out_t   o_data;

    hsf_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .op_word (op_word),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_data  (q_wr_data)
    );

    hsf_fifo #(
        .T     (hsf_entry_t),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_push),
        .wr_data (q_wr_data),
        .full    (q_full),
        .rd      (q_pop),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    hsf_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (q_rd_data),
        .q_pop   (q_pop),
        .o_full  (o_full),
        .o_push  (o_push),
        .o_data  (o_data)
    );

    hsf_fifo #(
        .T     (hsf_out_t),
        .DEPTH (OUT_DEPTH)
    ) u_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (o_push),
        .wr_data (o_data),
        .full    (o_full),
        .rd      (pop),
        .rd_data (line_word),
        .empty   (empty)
    );

    a_queue_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("byte queue written while full");

    a_out_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        o_push |-> !o_full)
        else $error("output queue written while full");

    a_pop_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && !q_empty) |-> (o_push && !o_full))
        else $error("queued byte consumed without an output word");

    a_fcs_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && op_word.operation == OP_FCS) |=> full)
        else $error("FCS word accepted without holding for its high byte");

endmodule

// File: design/hsf_fifo.sv
module hsf_fifo #(
    parameter type T     = logic,
    parameter int  DEPTH = 4
) (
    input  logic clk,
    input  logic rst_n,
    input  logic wr,
    input  T     wr_data,
    output logic full,
    input  logic rd,
    output T     rd_data,
    output logic empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    T               mem_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg;
    logic [AW-1:0]  rd_ptr_reg;
    logic [AW:0]    count_reg;
    logic           do_wr;
    logic           do_rd;

    assign full    = (count_reg == (AW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr && !full;
    assign do_rd   = rd && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + (AW+1)'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - (AW+1)'(1);
            end
        end
    end

endmodule

// File: design/hsf_front.sv
module hsf_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  hsf_pkg::hsf_in_t   op_word,
    input  logic               q_full,
    output logic               q_push,
    output hsf_pkg::hsf_entry_t q_data
);
    import hsf_pkg::*;

    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic        hold_reg;
    logic        hold_next;
    logic [7:0]  hi_reg;
    logic [7:0]  hi_next;
    logic [15:0] fcs;
    logic        accept;

    assign full   = hold_reg || q_full;
    assign accept = push && !full;
    assign fcs    = crc_reg ^ CRC_INIT;

    always_comb
    begin
        q_push    = 1'b0;
        q_data    = '0;
        crc_next  = crc_reg;
        hold_next = hold_reg;
        hi_next   = hi_reg;
        if (hold_reg)
        begin
            // second FCS byte
            if (!q_full)
            begin
                q_push       = 1'b1;
                q_data.data  = hi_reg;
                q_data.stuff = 1'b1;
                q_data.last  = 1'b1;
                hold_next    = 1'b0;
            end
        end
        else if (accept)
        begin
            case (hsf_op_t'(op_word.operation))
                OP_FLAG:
                begin
                    q_push       = 1'b1;
                    q_data.data  = op_word.data_byte;
                    q_data.stuff = 1'b0;
                    q_data.last  = 1'b1;
                end
                OP_DATA:
                begin
                    q_push       = 1'b1;
                    q_data.data  = op_word.data_byte;
                    q_data.stuff = 1'b1;
                    q_data.last  = 1'b1;
                    crc_next     = crc_byte(crc_reg, op_word.data_byte);
                end
                OP_FCS:
                begin
                    q_push       = 1'b1;
                    q_data.data  = fcs[7:0];
                    q_data.stuff = 1'b1;
                    q_data.last  = 1'b0;
                    hi_next      = fcs[15:8];
                    hold_next    = 1'b1;
                    crc_next     = CRC_INIT;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg  <= CRC_INIT;
            hold_reg <= 1'b0;
        end
        else
        begin
            crc_reg  <= crc_next;
            hold_reg <= hold_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg <= hi_next;
    end

endmodule

// File: design/hsf_back.sv
module hsf_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  hsf_pkg::hsf_entry_t q_data,
    output logic                q_pop,
    input  logic                o_full,
    output logic                o_push,
    output hsf_pkg::hsf_out_t   o_data
);
    import hsf_pkg::*;

    logic [8:0]  pending_reg;
    logic [8:0]  pending_next;
    logic [3:0]  count_reg;
    logic [3:0]  count_next;
    logic [2:0]  run_reg;
    logic [2:0]  run_next;
    hsf_stuff_t  st;
    logic [16:0] merged;
    logic [4:0]  total;

    assign st     = stuff_byte(q_data.data, q_data.stuff, run_reg);
    assign merged = {10'd0, pending_reg[6:0]} | ({7'd0, st.bits} << count_reg[2:0]);
    assign total  = {1'b0, count_reg} + {1'b0, st.len};

    always_comb
    begin
        q_pop        = 1'b0;
        o_push       = 1'b0;
        o_data       = '0;
        pending_next = pending_reg;
        count_next   = count_reg;
        run_next     = run_reg;
        if (!o_full && !q_empty)
        begin
            if (count_reg >= 4'd8)
            begin
                // whole byte left over: send it before appending
                o_push             = 1'b1;
                o_data.line_byte   = pending_reg[7:0];
                o_data.last_of_run = 1'b0;
                pending_next       = {8'd0, pending_reg[8]};
                count_next         = count_reg - 4'd8;
            end
            else
            begin
                q_pop              = 1'b1;
                o_push             = 1'b1;
                o_data.line_byte   = merged[7:0];
                o_data.last_of_run = q_data.last;
                pending_next       = merged[16:8];
                count_next         = 4'(total - 5'd8);
                run_next           = st.run;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            count_reg   <= '0;
            run_reg     <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
            count_reg   <= count_next;
            run_reg     <= run_next;
        end
    end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
    import hsf_pkg::*;

    typedef struct packed {
        hsf_op_t    op;
        logic [7:0] data;
        logic       typed;
        logic [1:0] n_typed;
        logic [7:0] e0;
        logic [7:0] e1;
    } script_row_t;

    logic     clk     = 1'b0;
    logic     rst_n   = 1'b0;
    logic     push    = 1'b0;
    logic     full;
    hsf_in_t  op_word = '0;
    logic     empty;
    logic     pop     = 1'b0;
    hsf_out_t line_word;

    hdlc_stuffing_framer_crc16 u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .op_word   (op_word),
        .empty     (empty),
        .pop       (pop),
        .line_word (line_word)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // op, data, typed, count, first byte, second byte
    script_row_t directed_rows [25] = '{
        '{OP_FLAG, 8'h7E, 1'b1, 2'd1, 8'h7E, 8'h00},
        '{OP_FCS,  8'h00, 1'b1, 2'd2, 8'h00, 8'h00},
        '{OP_NONE, 8'hA5, 1'b1, 2'd0, 8'h00, 8'h00},
        '{OP_FLAG, 8'h00, 1'b1, 2'd1, 8'h00, 8'h00},
        '{OP_FLAG, 8'hFF, 1'b1, 2'd1, 8'hFF, 8'h00},
        '{OP_DATA, 8'hFF, 1'b0, 2'd0, 8'h00, 8'h00},
        '{OP_DATA, 8'hFF, 1'b0, 2'd0, 8'h00, 8'h00},
        '{OP_DATA, 8'h1F, 1'b0, 2'd0, 8'h00, 8'h00},
        '{OP_DATA, 8'hF8, 1'b0, 2'd0, 8'h00, 8'h00},
        '{OP_DATA, 8'h7E, 1'b0, 2'd0, 8'h00, 8'h00},
        '{OP_FCS,  8'h00, 1'b0, 2'd0, 8'h00, 8'h00},
        '{OP_FLAG, 8'h7E, 1'b0, 2'd0, 8'h00, 8'h00},
        '{OP_DATA, 8'h00, 1'b0, 2'd0, 8'h00, 8'h00},
        '{OP_DATA, 8'h01, 1'b0, 2'd0, 8'h00, 8'h00},
        '{OP_DATA, 8'h80, 1'b0, 2'd0, 8'h00, 8'h00},
        '{OP_NONE, 8'hFF, 1'b0, 2'd0, 8'h00, 8'h00},
        '{OP_DATA, 8'hAA, 1'b0, 2'd0, 8'h00, 8'h00},
        '{OP_DATA, 8'h55, 1'b0, 2'd0, 8'h00, 8'h00},
        '{OP_FCS,  8'hFF, 1'b0, 2'd0, 8'h00, 8'h00},
        '{OP_FLAG, 8'h7E, 1'b0, 2'd0, 8'h00, 8'h00},
        '{OP_DATA, 8'hFF, 1'b0, 2'd0, 8'h00, 8'h00},
        '{OP_DATA, 8'hFF, 1'b0, 2'd0, 8'h00, 8'h00},
        '{OP_DATA, 8'hFF, 1'b0, 2'd0, 8'h00, 8'h00},
        '{OP_FCS,  8'h00, 1'b0, 2'd0, 8'h00, 8'h00},
        '{OP_FLAG, 8'h7E, 1'b0, 2'd0, 8'h00, 8'h00}
    };

    script_row_t op_script [$];
    hsf_out_t    line_due [$];

    int acc_idx       = 0;
    int faults        = 0;
    int script_items  = 0;
    int words_sent    = 0;
    int frames_closed = 0;
    int bytes_checked = 0;
    int stall_left    = 0;
    int stall_draw;
    bit calm          = 1'b0;

    // framer state mirror
    logic [15:0] fcs_crc   = CRC_INIT;
    logic [15:0] bit_hist  = '0;
    logic [23:0] pend_bits = '0;
    int unsigned pend_n    = 0;
    hsf_out_t    made [$];

    function automatic logic [15:0] crc_next(logic [15:0] c, logic [7:0] b);
        logic fb;
        for (int i = 0; i < 8; i++)
        begin
            fb = c[0] ^ b[i];
            c  = c >> 1;
            if (fb)
            begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    function void flush_line_byte();
        hsf_out_t w;
        if (pend_n >= 8 && made.size() < 4)
        begin
            w.line_byte   = pend_bits[7:0];
            w.last_of_run = 1'b0;
            made.push_back(w);
            pend_bits = pend_bits >> 8;
            pend_n    = pend_n - 8;
        end
    endfunction

    function void add_line_bits(logic [7:0] b, bit stuffed);
        logic [31:0] bits;
        logic [31:0] low;
        logic [15:0] want;
        int unsigned base;
        int unsigned extra;
        int unsigned pos;
        flush_line_byte();
        base      = pend_n;
        bits      = {8'h00, pend_bits} | ({24'h0, b} << base);
        pend_bits = bits[23:0];
        bit_hist  = {b, bit_hist[15:8]};
        pend_n    = pend_n + 8;
        extra     = 0;
        if (stuffed)
        begin
            for (int i = 0; i < 8; i++)
            begin
                want = 16'h01F0 << i;
                if ((bit_hist & want) == want)
                begin
                    bit_hist[8 + i] = 1'b0;
                    pos       = base + i + extra;
                    low       = (32'd1 << (pos + 1)) - 32'd1;
                    bits      = {8'h00, pend_bits};
                    bits      = (bits & low) | ((bits & ~low) << 1);
                    pend_bits = bits[23:0];
                    pend_n    = pend_n + 1;
                    extra     = extra + 1;
                end
            end
        end
        flush_line_byte();
    endfunction

    function void framer_step(hsf_in_t w);
        logic [15:0] fcs;
        hsf_out_t    tail;
        made.delete();
        case (hsf_op_t'(w.operation))
            OP_FLAG: add_line_bits(w.data_byte, 1'b0);
            OP_DATA:
            begin
                fcs_crc = crc_next(fcs_crc, w.data_byte);
                add_line_bits(w.data_byte, 1'b1);
            end
            OP_FCS:
            begin
                fcs = fcs_crc ^ CRC_INIT;
                add_line_bits(fcs[7:0], 1'b1);
                add_line_bits(fcs[15:8], 1'b1);
                fcs_crc = CRC_INIT;
            end
            default: ;
        endcase
        if (made.size() > 0)
        begin
            tail = made.pop_back();
            tail.last_of_run = 1'b1;
            made.push_back(tail);
        end
    endfunction

    function void note_fault(string msg);
        faults++;
        if (faults <= 10)
        begin
            $display("mismatch at %0t: %s", $time, msg);
        end
    endfunction

    function automatic int idle_len();
        int r;
        if (calm)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] pick_data();
        case ($urandom_range(0, 3))
            0:       return 8'hFF;
            1:       return 8'($urandom | $urandom);
            default: return 8'($urandom);
        endcase
    endfunction

    function void queue_item(hsf_op_t op, logic [7:0] d);
        script_row_t row;
        row      = '0;
        row.op   = op;
        row.data = d;
        op_script.push_back(row);
        if (op != OP_NONE)
        begin
            script_items++;
        end
    endfunction

    always @(posedge clk)
    begin : monitor
        script_row_t row;
        hsf_out_t    want;
        if (rst_n)
        begin
            if (push && !full)
            begin
                row = op_script[acc_idx];
                acc_idx++;
                framer_step(op_word);
                if (op_word.operation != OP_NONE)
                begin
                    words_sent++;
                end
                if (op_word.operation == OP_FCS)
                begin
                    frames_closed++;
                end
                if (row.typed)
                begin
                    if (row.n_typed >= 2'd1)
                    begin
                        want.line_byte   = row.e0;
                        want.last_of_run = (row.n_typed == 2'd1);
                        line_due.push_back(want);
                    end
                    if (row.n_typed == 2'd2)
                    begin
                        want.line_byte   = row.e1;
                        want.last_of_run = 1'b1;
                        line_due.push_back(want);
                    end
                end
                else
                begin
                    foreach (made[k])
                    begin
                        line_due.push_back(made[k]);
                    end
                end
            end
            if (pop && !empty)
            begin
                bytes_checked++;
                if (line_due.size() == 0)
                begin
                    note_fault($sformatf("unexpected word line_byte %02h last %0b",
                                         line_word.line_byte, line_word.last_of_run));
                end
                else
                begin
                    want = line_due.pop_front();
                    if (line_word.line_byte !== want.line_byte ||
                        line_word.last_of_run !== want.last_of_run)
                    begin
                        note_fault($sformatf("line_byte exp %02h got %02h, last exp %0b got %0b",
                                             want.line_byte, line_word.line_byte,
                                             want.last_of_run, line_word.last_of_run));
                    end
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop        <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            pop        <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            stall_draw = idle_len();
            pop        <= (stall_draw == 0);
            stall_left <= (stall_draw > 0) ? stall_draw - 1 : 0;
        end
    end

    initial
    begin
        int gap;
        int nd;
        foreach (directed_rows[i])
        begin
            op_script.push_back(directed_rows[i]);
        end
        // mostly well-formed frames, some loose noise words
        while (script_items < 235)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                queue_item(OP_FLAG, 8'h7E);
                if ($urandom_range(0, 4) == 0)
                begin
                    queue_item(OP_FLAG, 8'h7E);
                end
                nd = $urandom_range(1, 8);
                repeat (nd)
                begin
                    queue_item(OP_DATA, pick_data());
                end
                queue_item(OP_FCS, 8'($urandom));
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    queue_item(hsf_op_t'($urandom_range(0, 3)), 8'($urandom));
                end
            end
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < op_script.size(); i++)
        begin
            calm <= (i >= 25) && (((i / 40) % 4) == 3);
            gap = idle_len();
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            push    <= 1'b1;
            op_word <= hsf_in_t'({op_script[i].op, op_script[i].data});
            do
            begin
                @(posedge clk);
            end
            while (full);
        end
        push <= 1'b0;
        calm <= 1'b0;

        while (line_due.size() != 0 || acc_idx < op_script.size())
        begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);

        $display("covered %0d words (%0d frames closed with FCS), %0d line bytes checked",
                 words_sent, frames_closed, bytes_checked);
        $display("stuffing across byte edges, flag history, ignored op codes, random stalls");
        if (faults == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("%0d mismatches", faults);
            $display("Regression FAIL");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("timeout");
        $display("Regression FAIL");
        $finish;
    end

endmodule

// File: hdlc_stuffing_framer_crc16.f
design/hsf_pkg.sv
design/hsf_fifo.sv
design/hsf_front.sv
design/hsf_back.sv
design/hdlc_stuffing_framer_crc16.sv
tb/sv/tb.sv
